// ===== rtl/core/tsp_pkg.sv =====
// timer slot pool: shared types, codes and constants
// used by every module under rtl/core but tsp_wake_ram, depends on nothing else
`timescale 1ns / 1ps

package tsp_pkg;

   // field widths fixed by the request and response formats
   localparam int ACTION_W   = 2;
   localparam int TICK_W     = 64;
   localparam int DELAY_W    = 32;
   localparam int SLOT_W     = 4;
   localparam int STATUS_W   = 2;
   localparam int MASK_W     = 16;
   localparam int SLICE_W    = 32;
   localparam int TPU_W      = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W     = DELAY_W + TPU_W;

   // slot fields address at most this many slots
   localparam int SLOT_FIELD_SLOTS  = 16;
   localparam int NUM_SLOTS_DEFAULT = 16;

   // register reset values
   localparam logic [SLICE_W-1:0] SLICE_RESET = 32'd100000;
   localparam logic [TPU_W-1:0]   TPU_RESET   = 10'd10;

   // least wake tick when no slot is valid
   localparam logic [TICK_W-1:0] ALL_ONES = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_TICKS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_US = 1'b1;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NEXT   = 2'd3;

   // response status
   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STS_NOT_VALID = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [TICK_W-1:0]   now_tick;
      logic [DELAY_W-1:0]  delay_us;
      logic [SLOT_W-1:0]   slot;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_out;
      logic [MASK_W-1:0]   expired_mask;
      logic [TICK_W-1:0]   deadline;
   } rsp_type;

   // control from the sequencer to the scan accumulator
   typedef struct packed {
      logic clear;     // start a new scan
      logic en;        // read data of one slot arrives this cycle
      logic check;     // 1 expired mask, 0 least wake tick
      logic slot_vld;  // that slot holds a live timer
   } scan_ctl_type;

endpackage

// ===== rtl/core/tsp_wake_ram.sv =====
// timer slot pool: wake tick memory, one write and one registered read port
// depends on nothing else
`timescale 1ns / 1ps

module tsp_wake_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tsp_scan_unit.sv =====
// timer slot pool: accumulates one slot per enabled cycle into expired mask or least tick
// depends on tsp_pkg
`timescale 1ns / 1ps

module tsp_scan_unit #(
   parameter int POOL  = 16,
   parameter int IDX_W = 4
) (
   input  logic                       clock,
   input  tsp_pkg::scan_ctl_type      ctl,
   input  logic [IDX_W-1:0]           idx,
   input  logic [tsp_pkg::TICK_W-1:0] now_tick,
   input  logic [tsp_pkg::TICK_W-1:0] rd_data,
   output logic [POOL-1:0]            mask,
   output logic [tsp_pkg::TICK_W-1:0] least
);

   logic [POOL-1:0]            mask_ff;
   logic [POOL-1:0]            mask_in;
   logic [tsp_pkg::TICK_W-1:0] least_ff;
   logic [tsp_pkg::TICK_W-1:0] least_in;

   // one compare per slot, picked by scan mode
   always_comb begin
      mask_in  = mask_ff;
      least_in = least_ff;
      if (ctl.clear) begin
         mask_in  = '0;
         least_in = tsp_pkg::ALL_ONES;
      end else if (ctl.en && ctl.slot_vld) begin
         if (ctl.check) begin
            if (now_tick >= rd_data) begin
               mask_in[idx] = 1'b1;
            end
         end else if (rd_data < least_ff) begin
            least_in = rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mask_ff  <= mask_in;
      least_ff <= least_in;
   end

   assign mask  = mask_ff;
   assign least = least_ff;

endmodule

// ===== rtl/core/timer_slot_pool_core.sv =====
// timer_slot_pool_core: delete answers in the cycle after start, add after ST_ADD, check
// and next after ST_SCAN, ST_DRAIN and ST_FINAL, POOL being NUM_SLOTS capped at 16; busy
// is high in ST_ADD, ST_SCAN (one wake tick read per slot), ST_DRAIN, ST_FINAL; low on delete.
// One request at a time. Results are strobed for a single cycle; the receiver cannot stall.
// Synchronous reset clears all slot valid bits and restores register defaults.
// Depends on tsp_pkg, tsp_wake_ram and tsp_scan_unit.
`timescale 1ns / 1ps

module timer_slot_pool_core #(
   parameter int NUM_SLOTS = tsp_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  tsp_pkg::req_type               req_data,
   output logic                           rsp_strobe,
   output tsp_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [tsp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tsp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int POOL = (NUM_SLOTS < tsp_pkg::SLOT_FIELD_SLOTS) ?
                         NUM_SLOTS : tsp_pkg::SLOT_FIELD_SLOTS;
   localparam int IDX_W = (POOL > 1) ? $clog2(POOL) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL - 1);
   localparam logic [tsp_pkg::SLOT_W:0] POOL_LIMIT = (tsp_pkg::SLOT_W + 1)'(POOL);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ADD   = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_FINAL = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   tsp_pkg::req_type                req_ff, req_in;
   tsp_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   logic                            rsp_strobe_ff, rsp_strobe_in;
   logic [POOL-1:0]                 valid_ff, valid_in;
   logic [tsp_pkg::SLICE_W-1:0]     slice_ff;
   logic [tsp_pkg::TPU_W-1:0]       tpu_ff;
   logic [tsp_pkg::PROD_W-1:0]      product_ff, product_in;
   logic [tsp_pkg::TICK_W-1:0]      slice_end_ff, slice_end_in;
   logic [IDX_W-1:0]                cnt_ff, cnt_in;
   logic                            scan_en_ff, scan_en_in;
   logic [IDX_W-1:0]                scan_idx_ff;

   logic                            accept;
   logic                            free_found;
   logic [IDX_W-1:0]                free_idx;
   logic                            del_hit;
   logic [tsp_pkg::TICK_W-1:0]      wake_sum;
   logic                            ram_wr_en;
   logic                            ram_rd_en;
   logic [tsp_pkg::TICK_W-1:0]      ram_rd_data;
   tsp_pkg::scan_ctl_type           scan_ctl;
   logic [POOL-1:0]                 scan_mask;
   logic [tsp_pkg::TICK_W-1:0]      scan_least;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = POOL - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // delete target lies in the pool and holds a live timer
   assign del_hit = ({1'b0, req_data.slot} < POOL_LIMIT) &&
                    valid_ff[req_data.slot[IDX_W-1:0]];

   assign wake_sum  = req_ff.now_tick + tsp_pkg::TICK_W'(product_ff);
   assign ram_wr_en = (state_ff == ST_ADD) && free_found;
   assign ram_rd_en = (state_ff == ST_SCAN);

   // scan control, read data of the slot issued last cycle
   always_comb begin
      scan_ctl.clear    = accept && (req_data.action == tsp_pkg::ACT_CHECK ||
                                     req_data.action == tsp_pkg::ACT_NEXT);
      scan_ctl.en       = scan_en_ff;
      scan_ctl.check    = (req_ff.action == tsp_pkg::ACT_CHECK);
      scan_ctl.slot_vld = valid_ff[scan_idx_ff];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      valid_in      = valid_ff;
      product_in    = product_ff;
      slice_end_in  = slice_end_ff;
      cnt_in        = cnt_ff;
      scan_en_in    = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in       = req_data;
               product_in   = tsp_pkg::PROD_W'(req_data.delay_us) *
                              tsp_pkg::PROD_W'(tpu_ff);
               slice_end_in = req_data.now_tick + tsp_pkg::TICK_W'(slice_ff);
               cnt_in       = '0;
               case (req_data.action)
                  tsp_pkg::ACT_ADD: begin
                     state_in = ST_ADD;
                  end
                  tsp_pkg::ACT_DELETE: begin
                     rsp_strobe_in = 1'b1;
                     rsp_data_in   = '0;
                     if (del_hit) begin
                        valid_in[req_data.slot[IDX_W-1:0]] = 1'b0;
                     end else begin
                        rsp_data_in.status = tsp_pkg::STS_NOT_VALID;
                     end
                  end
                  default: begin
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_ADD: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '0;
            if (free_found) begin
               valid_in[free_idx]   = 1'b1;
               rsp_data_in.slot_out = tsp_pkg::SLOT_W'(free_idx);
               rsp_data_in.deadline = wake_sum;
            end else begin
               rsp_data_in.status = tsp_pkg::STS_FULL;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            scan_en_in = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '0;
            if (req_ff.action == tsp_pkg::ACT_CHECK) begin
               rsp_data_in.expired_mask = tsp_pkg::MASK_W'(scan_mask);
            end else begin
               rsp_data_in.deadline = (slice_end_ff < scan_least) ?
                                      slice_end_ff : scan_least;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         scan_en_ff    <= 1'b0;
         slice_ff      <= tsp_pkg::SLICE_RESET;
         tpu_ff        <= tsp_pkg::TPU_RESET;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         scan_en_ff    <= scan_en_in;
         if (csr_we) begin
            case (csr_index)
               tsp_pkg::CSR_SLICE_TICKS:  slice_ff <= csr_wdata;
               tsp_pkg::CSR_TICKS_PER_US: tpu_ff   <= csr_wdata[tsp_pkg::TPU_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      product_ff   <= product_in;
      slice_end_ff <= slice_end_in;
      cnt_ff       <= cnt_in;
      scan_idx_ff  <= cnt_ff;
      rsp_data_ff  <= rsp_data_in;
   end

   // wake ticks; writes and scan reads never overlap, one request at a time
   tsp_wake_ram #(
      .DEPTH  (POOL),
      .ADDR_W (IDX_W),
      .DATA_W (tsp_pkg::TICK_W)
   ) u_wake_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_idx),
      .wr_data (wake_sum),
      .rd_en   (ram_rd_en),
      .rd_addr (cnt_ff),
      .rd_data (ram_rd_data)
   );

   tsp_scan_unit #(
      .POOL  (POOL),
      .IDX_W (IDX_W)
   ) u_scan_unit (
      .clock    (clock),
      .ctl      (scan_ctl),
      .idx      (scan_idx_ff),
      .now_tick (req_ff.now_tick),
      .rd_data  (ram_rd_data),
      .mask     (scan_mask),
      .least    (scan_least)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // a successful add leaves its slot valid
   a_add_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && free_found) |=> valid_ff[$past(free_idx)])
      else $error("added slot not marked valid");

   // slot valid bits hold while the scan walks the memory
   a_scan_valid_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |=> $stable(valid_ff))
      else $error("valid bits changed during scan");

   // next deadline never lies beyond the end of the slice
   a_next_within_slice: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL && req_ff.action == tsp_pkg::ACT_NEXT) |=>
      (rsp_strobe && rsp_data.deadline <= $past(slice_end_ff)))
      else $error("next deadline beyond slice end");

endmodule

// ===== tb/timer_slot_pool_core_tb.sv =====
// timer_slot_pool_core_tb: self-checking bench for the timer slot pool core
// keeps a shadow copy of the pool and registers, drives request beats, checks responses
// depends on tsp_pkg and timer_slot_pool_core
`timescale 1ns / 1ps

module timer_slot_pool_core_tb;
   import tsp_pkg::*;

   localparam int POOL_SLOTS   = 16;
   localparam int ITEMS_TOTAL  = 1900;
   localparam int PHASES       = 6;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 30;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SLICE_TICKS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the pool and its registers
   logic [TICK_W-1:0]     shadow_wake [POOL_SLOTS] = '{default: '0};
   logic [POOL_SLOTS-1:0] shadow_live  = '0;
   logic [SLICE_W-1:0]    shadow_slice = SLICE_RESET;
   logic [TPU_W-1:0]      shadow_tpu   = TPU_RESET;

   rsp_type           awaited_rsp_q[$];
   int                mismatches  = 0;
   int                idle_cycles = 0;
   int                idle_pct    = 0;
   logic [TICK_W-1:0] time_base   = '0;

   timer_slot_pool_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response of the pool to one request, updating the shadow state
   function automatic rsp_type apply_pool_action(req_type r);
      rsp_type           res;
      logic [TICK_W-1:0] least;
      logic [TICK_W-1:0] slice_end;
      logic [TICK_W-1:0] delay_ext;
      logic [TICK_W-1:0] tpu_ext;
      logic [TICK_W-1:0] slice_ext;
      logic              claimed;
      res       = '0;
      least     = ALL_ONES;
      delay_ext = TICK_W'(r.delay_us);
      tpu_ext   = TICK_W'(shadow_tpu);
      slice_ext = TICK_W'(shadow_slice);
      slice_end = r.now_tick + slice_ext;
      claimed   = 1'b0;
      case (r.action)
         ACT_ADD: begin
            res.status = STS_FULL;
            for (int i = 0; i < POOL_SLOTS; i++) begin
               if (!claimed && !shadow_live[i]) begin
                  shadow_wake[i] = r.now_tick + delay_ext * tpu_ext;
                  shadow_live[i] = 1'b1;
                  res.status     = STS_OK;
                  res.slot_out   = SLOT_W'(i);
                  res.deadline   = shadow_wake[i];
                  claimed        = 1'b1;
               end
            end
         end
         ACT_DELETE: begin
            if (shadow_live[r.slot])
               shadow_live[r.slot] = 1'b0;
            else
               res.status = STS_NOT_VALID;
         end
         ACT_CHECK: begin
            for (int i = 0; i < POOL_SLOTS; i++)
               if (shadow_live[i] && r.now_tick >= shadow_wake[i])
                  res.expired_mask[i] = 1'b1;
         end
         default: begin
            for (int i = 0; i < POOL_SLOTS; i++)
               if (shadow_live[i] && shadow_wake[i] < least)
                  least = shadow_wake[i];
            res.deadline = (slice_end < least) ? slice_end : least;
         end
      endcase
      return res;
   endfunction

   function automatic logic [TICK_W-1:0] rand_tick();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type pool_req(logic [ACTION_W-1:0] action,
                                        logic [TICK_W-1:0] now, logic [DELAY_W-1:0] delay,
                                        logic [SLOT_W-1:0] slot);
      req_type r;
      r.action   = action;
      r.now_tick = now;
      r.delay_us = delay;
      r.slot     = slot;
      return r;
   endfunction

   // mostly plausible traffic around a moving time base, some pure noise
   function automatic req_type random_pool_req();
      req_type r;
      int      live;
      int      pick;
      int      add_w;
      int      del_w;
      live = $countones(shadow_live);
      r    = pool_req(ACT_ADD, rand_tick(), $urandom, SLOT_W'($urandom_range(0, 15)));
      if ($urandom_range(0, 99) < 12) begin
         r.action = ACTION_W'($urandom_range(0, 3));
         return r;
      end
      time_base = time_base + $urandom_range(0, 3000);
      if ($urandom_range(0, 63) == 0)
         time_base = time_base + {32'd0, $urandom};
      r.now_tick = time_base;
      add_w = (live >= 14) ? 20 : 40;
      del_w = (live >= 14) ? 40 : 20;
      pick  = $urandom_range(0, 99);
      if (pick < add_w) begin
         r.action = ACT_ADD;
         if ($urandom_range(0, 7) != 0)
            r.delay_us = $urandom_range(0, 200);
      end else if (pick < add_w + del_w) begin
         r.action = ACT_DELETE;
         if (live > 0 && $urandom_range(0, 3) != 0)
            while (!shadow_live[r.slot])
               r.slot = SLOT_W'($urandom_range(0, 15));
      end else if (pick < 80) begin
         r.action   = ACT_CHECK;
         r.now_tick = time_base + $urandom_range(0, 4000) - 2000;
      end else begin
         r.action = ACT_NEXT;
      end
      return r;
   endfunction

   // one request beat: hold start until the block takes it
   task automatic send_timer_request(input req_type item);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      awaited_rsp_q.push_back(apply_pool_action(item));
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (awaited_rsp_q.size() != 0 || busy !== 1'b0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      wait_for_drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_SLICE_TICKS)
         shadow_slice = value;
      else
         shadow_tpu = value[TPU_W-1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic note_field(input string field, input logic [TICK_W-1:0] want,
                             input logic [TICK_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
   endtask

   // response checker: every strobed beat against the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (awaited_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response beat with nothing outstanding", $time);
         end else begin
            want = awaited_rsp_q.pop_front();
            if (rsp_data.status !== want.status)
               note_field("status", TICK_W'(want.status), TICK_W'(rsp_data.status));
            if (rsp_data.slot_out !== want.slot_out)
               note_field("slot_out", TICK_W'(want.slot_out), TICK_W'(rsp_data.slot_out));
            if (rsp_data.expired_mask !== want.expired_mask)
               note_field("expired_mask", TICK_W'(want.expired_mask),
                          TICK_W'(rsp_data.expired_mask));
            if (rsp_data.deadline !== want.deadline)
               note_field("deadline", want.deadline, rsp_data.deadline);
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_strobe === 1'b1 || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // empty pool: next falls back to the slice, nothing expires, delete is refused
   task automatic test_empty_pool();
      send_timer_request(pool_req(ACT_NEXT, '0, '0, '0));
      send_timer_request(pool_req(ACT_CHECK, ALL_ONES, '1, '1));
      send_timer_request(pool_req(ACT_DELETE, '0, '0, '0));
   endtask

   // zero registers: add wakes at now, next is at most now
   task automatic test_zero_registers();
      write_csr(CSR_SLICE_TICKS, '0);
      write_csr(CSR_TICKS_PER_US, '0);
      send_timer_request(pool_req(ACT_ADD, 64'h1234_5678_9abc_def0, '1, '1));
      send_timer_request(pool_req(ACT_NEXT, 64'h100, '0, '0));
      write_csr(CSR_SLICE_TICKS, SLICE_RESET);
      write_csr(CSR_TICKS_PER_US, TPU_RESET);
   endtask

   // fill the pool with wrapping and huge delays, then check and next, free, free again and reclaim
   task automatic test_full_pool();
      send_timer_request(pool_req(ACT_ADD, ALL_ONES, 32'd1, '0));
      send_timer_request(pool_req(ACT_ADD, 64'd1000, '1, '0));
      for (int i = 3; i < POOL_SLOTS; i++)
         send_timer_request(pool_req(ACT_ADD, 64'd5000, i * 7, '0));
      send_timer_request(pool_req(ACT_ADD, '0, 32'd5, '0));
      send_timer_request(pool_req(ACT_CHECK, 64'd5100, '0, '0));
      send_timer_request(pool_req(ACT_NEXT, ALL_ONES - 5, '0, '0));
      send_timer_request(pool_req(ACT_DELETE, '0, '0, 4'd15));
      send_timer_request(pool_req(ACT_DELETE, '0, '0, 4'd15));
      send_timer_request(pool_req(ACT_ADD, 64'd7, 32'd3, '0));
   endtask

   // random traffic under one register setting
   task automatic test_random_traffic(input int phase, input logic [CSR_DATA_W-1:0] slice,
                                      input logic [CSR_DATA_W-1:0] tpu, input int items,
                                      input bit allow_idle);
      write_csr(CSR_SLICE_TICKS, slice);
      write_csr(CSR_TICKS_PER_US, tpu);
      time_base = (phase == 1) ? ALL_ONES - $urandom_range(0, 3000000) : rand_tick();
      for (int n = 0; n < items; n++) begin
         if (n % 40 == 0)
            idle_pct = (allow_idle && $urandom_range(0, 2) != 0) ? 30 : 0;
         send_timer_request(random_pool_req());
         if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
   endtask

   initial begin
      int per_phase;
      per_phase = (ITEMS_TOTAL - 26) / PHASES;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_pool();
      test_zero_registers();
      test_full_pool();
      test_random_traffic(0, SLICE_RESET, TPU_RESET, per_phase, 1'b1);
      test_random_traffic(1, '1, '1, per_phase, 1'b1);
      test_random_traffic(2, 32'd1, 32'd1, per_phase, 1'b1);
      test_random_traffic(3, '0, 32'hFFFF_FC00, per_phase, 1'b1);
      test_random_traffic(4, $urandom, $urandom, per_phase, 1'b1);
      test_random_traffic(5, $urandom, $urandom, per_phase, 1'b0);
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_rsp_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
